/* src/ulbp_pkg.sv */
package ulbp_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int SIZE_W      = 9;
    localparam int PIX_W       = 8;
    localparam int CODE_W      = 8;
    localparam int BIN_W       = 6;
    localparam int CNT_W       = 16;
    localparam int NUM_BINS    = 59;
    localparam int LAST_BIN    = 58;
    localparam int NUM_CODES   = 256;
    localparam int QUEUE_DEPTH = 4;
    localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // one entry between the pixel front and the histogram back
    typedef struct packed {
        logic                has_code;
        logic [CODE_W-1:0]   code;
        logic                frame_end;
    } t_entry;

    typedef logic [NUM_CODES-1:0][BIN_W-1:0] t_bin_map;

    // uniform codes (at most two circular transitions) get bins in code order
    function automatic t_bin_map build_bin_map();
        t_bin_map          m;
        logic [CODE_W-1:0] c;
        logic [CODE_W-1:0] d;
        int                nxt;
        nxt = 0;
        for (int i = 0; i < NUM_CODES; i++) begin
            c = CODE_W'(i);
            d = c ^ {c[0], c[CODE_W-1:1]};
            if ($countones(d) <= 2 && nxt < LAST_BIN) begin
                m[i] = BIN_W'(nxt);
                nxt  = nxt + 1;
            end else begin
                m[i] = BIN_W'(LAST_BIN);
            end
        end
        return m;
    endfunction

    localparam t_bin_map BIN_MAP = build_bin_map();

    // clamp a size register to 3..max and return size - 1
    function automatic logic [COL_W-1:0] width_last(logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] m;
        if (v < SIZE_W'(3)) begin
            m = SIZE_W'(2);
        end else if (v > SIZE_W'(MAX_WIDTH)) begin
            m = SIZE_W'(MAX_WIDTH - 1);
        end else begin
            m = v - SIZE_W'(1);
        end
        return m[COL_W-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] height_last(logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] m;
        if (v < SIZE_W'(3)) begin
            m = SIZE_W'(2);
        end else if (v > SIZE_W'(MAX_HEIGHT)) begin
            m = SIZE_W'(MAX_HEIGHT - 1);
        end else begin
            m = v - SIZE_W'(1);
        end
        return m[ROW_W-1:0];
    endfunction

endpackage

/* src/ulbp_queue.sv */
module ulbp_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  ulbp_pkg::t_entry              i_entry,
    input  logic                          i_pop,
    output ulbp_pkg::t_entry              o_entry,
    output logic                          o_valid,
    output logic [ulbp_pkg::QCNT_W-1:0]   o_count
);
    import ulbp_pkg::*;

    t_entry             r_mem [QUEUE_DEPTH];
    logic [QADDR_W-1:0] r_wp;
    logic [QADDR_W-1:0] r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic               pop_ok;

    assign pop_ok  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QADDR_W'(1);
            end
            if (pop_ok) begin
                r_rp <= r_rp + QADDR_W'(1);
            end
            if (i_push && !pop_ok) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (!i_push && pop_ok) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

/* src/ulbp_front.sv */
module ulbp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic [ulbp_pkg::COL_W-1:0]    i_wlast,
    input  logic [ulbp_pkg::ROW_W-1:0]    i_hlast,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ulbp_pkg::PIX_W-1:0]    i_pixel,
    input  logic [ulbp_pkg::QCNT_W-1:0]   i_q_count,
    output logic                          o_push,
    output ulbp_pkg::t_entry              o_entry
);
    import ulbp_pkg::*;

    // two previous rows, one memory each
    logic [PIX_W-1:0] r_top_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_mid_mem [MAX_WIDTH];

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic              accept;
    logic [QCNT_W:0]   pend;

    // stage 1 (line store data back)
    logic              r_p1_v;
    logic [PIX_W-1:0]  r_p1_px;
    logic [COL_W-1:0]  r_p1_col;
    logic              r_p1_code_en;
    logic              r_p1_end;
    logic [PIX_W-1:0]  r_top;
    logic [PIX_W-1:0]  r_mid;

    // window: w1 = previous column, w0 = the one before
    logic [PIX_W-1:0]  r_w0_top, r_w0_mid, r_w0_bot;
    logic [PIX_W-1:0]  r_w1_top, r_w1_mid, r_w1_bot;
    logic [CODE_W-1:0] code;

    assign pend    = (QCNT_W+1)'(i_q_count) + (QCNT_W+1)'(r_p1_v);
    assign o_ready = pend < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept  = i_valid && o_ready;

    always_comb begin
        code[0] = r_w1_mid >= r_w1_top;
        code[1] = r_w1_mid >= r_w0_top;
        code[2] = r_w1_mid >= r_w0_mid;
        code[3] = r_w1_mid >= r_w0_bot;
        code[4] = r_w1_mid >= r_w1_bot;
        code[5] = r_w1_mid >= r_p1_px;
        code[6] = r_w1_mid >= r_mid;
        code[7] = r_w1_mid >= r_top;
    end

    assign o_push             = r_p1_v && (r_p1_code_en || r_p1_end);
    assign o_entry.has_code   = r_p1_code_en;
    assign o_entry.code       = code;
    assign o_entry.frame_end  = r_p1_end;

    // line stores: read at accept, written in the cycle after at the same column
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top <= r_top_mem[r_col];
            r_mid <= r_mid_mem[r_col];
        end
        if (r_p1_v) begin
            r_top_mem[r_p1_col] <= r_mid;
            r_mid_mem[r_p1_col] <= r_p1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1_px      <= i_pixel;
            r_p1_col     <= r_col;
            r_p1_code_en <= (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
            r_p1_end     <= (r_col == i_wlast) && (r_row == i_hlast);
        end
        if (r_p1_v) begin
            r_w0_top <= r_w1_top;
            r_w0_mid <= r_w1_mid;
            r_w0_bot <= r_w1_bot;
            r_w1_top <= r_top;
            r_w1_mid <= r_mid;
            r_w1_bot <= r_p1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_p1_v <= 1'b0;
        end else if (i_restart) begin
            r_col  <= '0;
            r_row  <= '0;
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v <= accept;
            if (accept) begin
                if (r_col == i_wlast) begin
                    r_col <= '0;
                    if (r_row == i_hlast) begin
                        r_row <= '0;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

endmodule

/* src/ulbp_back.sv */
module ulbp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  ulbp_pkg::t_entry              i_entry,
    input  logic                          i_q_valid,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ulbp_pkg::BIN_W-1:0]    o_bin_index,
    output logic [ulbp_pkg::CNT_W-1:0]    o_bin_count,
    output logic                          o_bin_last
);
    import ulbp_pkg::*;

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic [CNT_W-1:0]    r_hist [NUM_BINS];
    logic [NUM_BINS-1:0] r_hv;

    logic                r_state;
    logic [BIN_W-1:0]    r_didx;
    logic                r_ov;
    logic [BIN_W-1:0]    r_oidx;

    logic [CNT_W-1:0]    r_rd;
    logic                r_rd_ok;
    logic                r_b1_v;
    logic                r_b1_end;
    logic [BIN_W-1:0]    r_b1_bin;

    // last write, forwarded to a back-to-back hit on the same bin
    logic                r_wr_v;
    logic [BIN_W-1:0]    r_wr_bin;
    logic [CNT_W-1:0]    r_wr_val;

    logic [BIN_W-1:0]    bin;
    logic                issue;
    logic                rd_en;
    logic [BIN_W-1:0]    rd_addr;
    logic [CNT_W-1:0]    cur;
    logic [CNT_W-1:0]    nxt;

    assign bin   = BIN_MAP[i_entry.code];
    assign o_pop = (r_state == ST_RUN) && !r_b1_end && !r_ov && i_q_valid;
    assign issue = (r_state == ST_DUMP) && (!r_ov || i_ready);
    assign rd_en   = o_pop || issue;
    assign rd_addr = issue ? r_didx : bin;

    always_comb begin
        if (r_wr_v && (r_wr_bin == r_b1_bin)) begin
            cur = r_wr_val;
        end else if (r_rd_ok) begin
            cur = r_rd;
        end else begin
            cur = '0;
        end
        nxt = (cur == {CNT_W{1'b1}}) ? cur : cur + CNT_W'(1);
    end

    assign o_valid     = r_ov;
    assign o_bin_index = r_oidx;
    assign o_bin_count = r_rd_ok ? r_rd : '0;
    assign o_bin_last  = (r_oidx == BIN_W'(LAST_BIN));

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_hist[rd_addr];
        end
        if (r_b1_v) begin
            r_hist[r_b1_bin] <= nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_ok <= r_hv[rd_addr];
        end
        if (o_pop) begin
            r_b1_bin <= bin;
        end
        if (r_b1_v) begin
            r_wr_bin <= r_b1_bin;
            r_wr_val <= nxt;
        end
        if (issue) begin
            r_oidx <= r_didx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_hv     <= '0;
            r_state  <= ST_RUN;
            r_didx   <= '0;
            r_ov     <= 1'b0;
            r_b1_v   <= 1'b0;
            r_b1_end <= 1'b0;
            r_wr_v   <= 1'b0;
        end else begin
            r_b1_v   <= o_pop && i_entry.has_code;
            r_b1_end <= o_pop && i_entry.frame_end;
            if (r_b1_v) begin
                r_hv[r_b1_bin] <= 1'b1;
                r_wr_v         <= 1'b1;
            end
            if (r_b1_end) begin
                r_state <= ST_DUMP;
                r_didx  <= '0;
                r_wr_v  <= 1'b0;
            end
            case (r_state)
                ST_DUMP: begin
                    if (issue) begin
                        r_hv[r_didx] <= 1'b0;
                        r_ov         <= 1'b1;
                        if (r_didx == BIN_W'(LAST_BIN)) begin
                            r_state <= ST_RUN;
                        end else begin
                            r_didx <= r_didx + BIN_W'(1);
                        end
                    end
                end
                default: begin
                    if (r_ov && i_ready) begin
                        r_ov <= 1'b0;
                    end
                end
            endcase
        end
    end

endmodule

/* src/uniform_lbp_histogram.sv */
// Channel   Dir  Beat fields (tdata from bit 0 up)
// s_axis    in   pixel[7:0]
// m_axis    out  bin_index[5:0], bin_count[21:6], zero pad[23:22]; tlast = bin_last
// apb       in   0x0 image_width[8:0], 0x4 image_height[8:0]
//
// One pixel beat per cycle within a frame while the 4-entry queue has room, dumps too.
// Front: line store read at the accepting edge, code pushed in the next cycle.
// Back: bin read at pop, written in the cycle after. A dump starts once the frame-end
// entry is popped from the queue, then one beat per cycle while tready is high.
// Reset (i_rst_n low, synchronous) clears counters, bins and queue; sizes go
// to 12x12. Any size write restarts the frame and clears the bins.
module uniform_lbp_histogram (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // pixel[7:0]
    // bin dump
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // bin_index[5:0], bin_count[21:6], pad
    output logic        m_axis_tlast,    // bin_last
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ulbp_pkg::*;

    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic              cfg_wr;
    logic [COL_W-1:0]  wlast;
    logic [ROW_W-1:0]  hlast;

    logic              q_push;
    t_entry            q_in;
    logic              q_pop;
    t_entry            q_out;
    logic              q_valid;
    logic [QCNT_W-1:0] q_count;

    logic [BIN_W-1:0]  bin_index;
    logic [CNT_W-1:0]  bin_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(r_height) : 32'(r_width);

    // every size write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(12);
            r_height <= SIZE_W'(12);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HEIGHT) begin
                r_height <= pwdata[SIZE_W-1:0];
            end else begin
                r_width <= pwdata[SIZE_W-1:0];
            end
        end
    end

    assign wlast = width_last(r_width);
    assign hlast = height_last(r_height);

    ulbp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (cfg_wr),
        .i_wlast   (wlast),
        .i_hlast   (hlast),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_pixel   (s_axis_tdata),
        .i_q_count (q_count),
        .o_push    (q_push),
        .o_entry   (q_in)
    );

    ulbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_valid (q_valid),
        .o_count (q_count)
    );

    ulbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (cfg_wr),
        .i_entry     (q_out),
        .i_q_valid   (q_valid),
        .o_pop       (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_bin_index (bin_index),
        .o_bin_count (bin_count),
        .o_bin_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, bin_count, bin_index};

endmodule
